/* rtl/core/breakpoint_table_defines.svh */
// Assertion macros shared by the breakpoint table checkers.
// Needs nothing else; included by bare name.
`ifndef BREAKPOINT_TABLE_DEFINES_SVH
`define BREAKPOINT_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("breakpoint_table check failed");

// next-cycle implication, disabled while reset is low
`define BT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("breakpoint_table check failed");

`endif

/* rtl/core/bt_pkg.sv */
// Shared types and constants of the breakpoint table.
// No dependencies; used by bt_cell, breakpoint_table and bt_checker.
`timescale 1ns / 1ps

package bt_pkg;

    localparam int ENTRY_COUNT_DEF = 32;
    localparam int NUM_W           = 5;
    localparam int WORD_W          = 32;

    localparam logic [WORD_W-1:0] BREAK_MASK = 32'hffff8000;
    localparam logic [WORD_W-1:0] BREAK_WORD = 32'h002a0000;

    localparam logic [WORD_W-1:0] MEM_BASE_RST = 32'h80000000;
    localparam logic [WORD_W-1:0] MEM_SIZE_RST = 32'h08000000;

    // register indexes
    localparam logic REG_MEM_BASE = 1'b0;
    localparam logic REG_MEM_SIZE = 1'b1;

    // action codes on the input
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_SCAN   = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OUTSIDE   = 3'd1;
    localparam logic [2:0] ST_ALREADY   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // operation carried down the cell row
    typedef enum logic [1:0] {
        OP_INS  = 2'd0,
        OP_DEL  = 2'd1,
        OP_SCAN = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] pc;
        logic [WORD_W-1:0] word;
        logic [NUM_W-1:0]  num;
    } t_req;

    // token handed from cell to cell; tok marks the live position
    typedef struct packed {
        logic              tok;
        logic              done;
        logic [NUM_W-1:0]  idx;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] word;
    } t_carry;

endpackage

/* rtl/core/bt_cell.sv */
// One breakpoint entry: valid bit, saved pc, saved original word.
// Uses bt_pkg; instantiated in a row by breakpoint_table.
`timescale 1ns / 1ps

module bt_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bt_pkg::t_req   i_req,
    input  bt_pkg::t_carry i_carry,
    output bt_pkg::t_carry o_carry
);

    localparam logic [bt_pkg::NUM_W-1:0] IDX_NUM = bt_pkg::NUM_W'(IDX % 32);
    localparam bit DEL_OK = (IDX < 32);

    logic                      r_valid;
    logic [bt_pkg::WORD_W-1:0] r_addr;
    logic [bt_pkg::WORD_W-1:0] r_orig;
    bt_pkg::t_carry            r_carry;

    logic           n_valid;
    logic           w_write;
    bt_pkg::t_carry n_carry;

    always_comb begin
        n_carry = i_carry;
        n_valid = r_valid;
        w_write = 1'b0;
        if (i_carry.tok) begin
            case (i_req.op)
                bt_pkg::OP_INS: begin
                    // first free entry along the row claims the insert
                    if (!i_carry.done && !r_valid) begin
                        n_valid      = 1'b1;
                        w_write      = 1'b1;
                        n_carry.done = 1'b1;
                        n_carry.idx  = IDX_NUM;
                    end
                end
                bt_pkg::OP_DEL: begin
                    if (DEL_OK && i_req.num == IDX_NUM && r_valid) begin
                        n_valid      = 1'b0;
                        n_carry.done = 1'b1;
                        n_carry.addr = r_addr;
                        n_carry.word = r_orig;
                    end
                end
                bt_pkg::OP_SCAN: begin
                    if (!i_carry.done && r_valid && r_addr == i_req.pc) begin
                        n_carry.done = 1'b1;
                        n_carry.word = r_orig;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_carry.tok <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_carry <= n_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_addr <= i_req.pc;
            r_orig <= i_req.word;
        end
    end

    assign o_carry = r_carry;

endmodule

/* rtl/core/breakpoint_table.sv */
// Top level of the breakpoint table: stream ports, window/break checks, cell row.
// Uses bt_pkg and bt_cell.
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: pc, word, number
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: status .. write_word
// cfg       in   i_cfg_we                      i_cfg_index, i_cfg_data
//
// One item is in the table at a time: a token walks the cell row one entry per
// cycle, and a new beat is taken only once the result is in the output register.
// The output register holds a result while the next beat is taken in.
// Reset is synchronous: it frees every entry and restores the window registers.
// A stalled output holds the finished result; the row waits before handing it over.
`timescale 1ns / 1ps

module breakpoint_table #(
    parameter int ENTRY_COUNT = bt_pkg::ENTRY_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // pc[31:0], fetched_word[63:32], entry_number[68:64]
    input  logic [1:0]   s_axis_tuser,  // action[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // status[2:0], assigned_number[7:3], hit[8],
                                        // saved_word[40:9], write_request[41],
                                        // write_address[73:42], write_word[105:74]
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state         r_state;
    bt_pkg::t_req   r_req;
    logic [2:0]     r_pre_status;
    logic [31:0]    r_base;
    logic [31:0]    r_size;
    logic           r_start;
    bt_pkg::t_carry r_fin;

    logic           r_ovalid;
    logic [2:0]     r_status;
    logic [4:0]     r_assigned;
    logic           r_hit;
    logic [31:0]    r_saved;
    logic           r_wreq;
    logic [31:0]    r_waddr;
    logic [31:0]    r_wword;

    bt_pkg::t_carry w_chain [ENTRY_COUNT+1];

    logic           w_in_acc;
    logic [31:0]    w_pc;
    logic [31:0]    w_word;
    logic           w_inside;
    logic           w_brk;
    bt_pkg::t_op    w_op;
    logic [2:0]     w_pre;
    logic           w_load;

    logic [2:0]     n_status;
    logic [4:0]     n_assigned;
    logic           n_hit;
    logic [31:0]    n_saved;
    logic           n_wreq;
    logic [31:0]    n_waddr;
    logic [31:0]    n_wword;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_pc          = s_axis_tdata[31:0];
    assign w_word        = s_axis_tdata[63:32];
    assign w_inside      = (w_pc - r_base) < r_size;
    assign w_brk         = (w_word & bt_pkg::BREAK_MASK) == bt_pkg::BREAK_WORD;

    always_comb begin
        w_op  = bt_pkg::OP_NONE;
        w_pre = bt_pkg::ST_OK;
        unique case (s_axis_tuser)
            bt_pkg::ACT_INSERT: begin
                if (!w_inside) begin
                    w_pre = bt_pkg::ST_OUTSIDE;
                end else if (w_brk) begin
                    w_pre = bt_pkg::ST_ALREADY;
                end else begin
                    w_op = bt_pkg::OP_INS;
                end
            end
            bt_pkg::ACT_DELETE: w_op = bt_pkg::OP_DEL;
            bt_pkg::ACT_SCAN:   w_op = bt_pkg::OP_SCAN;
            default: ;
        endcase
    end

    // token entering the first cell
    always_comb begin
        w_chain[0]      = '0;
        w_chain[0].tok  = r_start;
    end

    for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
        bt_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (r_req),
            .i_carry (w_chain[g]),
            .o_carry (w_chain[g+1])
        );
    end

    // result from the token that left the row
    always_comb begin
        n_status   = bt_pkg::ST_OK;
        n_assigned = '0;
        n_hit      = 1'b0;
        n_saved    = '0;
        n_wreq     = 1'b0;
        n_waddr    = '0;
        n_wword    = '0;
        case (r_req.op)
            bt_pkg::OP_INS: begin
                if (r_fin.done) begin
                    n_assigned = r_fin.idx;
                    n_wreq     = 1'b1;
                    n_waddr    = r_req.pc;
                    n_wword    = bt_pkg::BREAK_WORD;
                end else begin
                    n_status = bt_pkg::ST_FULL;
                end
            end
            bt_pkg::OP_DEL: begin
                if (r_fin.done) begin
                    n_wreq  = 1'b1;
                    n_waddr = r_fin.addr;
                    n_wword = r_fin.word;
                end else begin
                    n_status = bt_pkg::ST_NOT_FOUND;
                end
            end
            bt_pkg::OP_SCAN: begin
                n_hit   = r_fin.done;
                n_saved = r_fin.done ? r_fin.word : '0;
            end
            default: n_status = r_pre_status;
        endcase
    end

    assign w_load = (r_state == S_DONE) && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
            r_base   <= bt_pkg::MEM_BASE_RST;
            r_size   <= bt_pkg::MEM_SIZE_RST;
        end else begin
            r_start <= w_in_acc;
            unique case (r_state)
                S_IDLE: if (w_in_acc) r_state <= S_RUN;
                S_RUN:  if (w_chain[ENTRY_COUNT].tok) r_state <= S_DONE;
                S_DONE: if (w_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bt_pkg::REG_MEM_BASE: r_base <= i_cfg_data;
                    bt_pkg::REG_MEM_SIZE: r_size <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req.op     <= w_op;
            r_req.pc     <= w_pc;
            r_req.word   <= w_word;
            r_req.num    <= s_axis_tdata[68:64];
            r_pre_status <= w_pre;
        end
        if (r_state == S_RUN && w_chain[ENTRY_COUNT].tok) begin
            r_fin <= w_chain[ENTRY_COUNT];
        end
        if (w_load) begin
            r_status   <= n_status;
            r_assigned <= n_assigned;
            r_hit      <= n_hit;
            r_saved    <= n_saved;
            r_wreq     <= n_wreq;
            r_waddr    <= n_waddr;
            r_wword    <= n_wword;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_wword, r_waddr, r_wreq, r_saved, r_hit,
                            r_assigned, r_status};

endmodule

/* rtl/core/bt_checker.sv */
// Port-level checks of the breakpoint table, bound to the top level.
// Uses bt_pkg and breakpoint_table_defines.svh.
`timescale 1ns / 1ps
`include "breakpoint_table_defines.svh"

module bt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata
);

    logic [2:0] w_status;
    logic       w_hit;
    logic       w_wreq;
    logic       w_out_err;
    logic       w_out_hit;
    logic       w_out_stall;

    assign w_status    = m_axis_tdata[2:0];
    assign w_hit       = m_axis_tdata[8];
    assign w_wreq      = m_axis_tdata[41];
    assign w_out_err   = m_axis_tvalid && (w_status != bt_pkg::ST_OK);
    assign w_out_hit   = m_axis_tvalid && w_hit;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;

    // any error status means no memory write
    `BT_ASSERT_IMPL(a_err_no_write, i_clk, i_rst_n, w_out_err, !w_wreq)

    // a scan hit is a clean result without a write
    `BT_ASSERT_IMPL(a_hit_clean, i_clk, i_rst_n, w_out_hit, w_status == bt_pkg::ST_OK && !w_wreq)

    // one item at a time: input closes right after a beat is taken
    `BT_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // stalled result holds
    `BT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind breakpoint_table bt_checker u_bt_checker (.*);

/* verif/breakpoint_table_tb.sv */
// Self-checking testbench for breakpoint_table: stream stimulus, a table predictor
// and a beat-by-beat result check. Depends on bt_pkg and the breakpoint_table RTL.
`timescale 1ns / 1ps

module breakpoint_table_tb;
    import bt_pkg::*;

    localparam int ENTRY_COUNT = ENTRY_COUNT_DEF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = ENTRY_COUNT + 8;

    // one result beat, MSB first so it lines up with m_axis_tdata[105:0]
    typedef struct packed {
        logic [31:0] wword;
        logic [31:0] waddr;
        logic        wreq;
        logic [31:0] saved;
        logic        hit;
        logic [4:0]  number;
        logic [2:0]  status;
    } bp_result_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;   // pc[31:0], fetched_word[63:32], entry_number[68:64]
    logic [1:0]   s_axis_tuser;   // action[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;   // status[2:0], assigned_number[7:3], hit[8], saved_word[40:9],
                                  // write_request[41], write_address[73:42], write_word[105:74]
    logic         i_cfg_we;
    logic         i_cfg_index;
    logic [31:0]  i_cfg_data;

    // predictor copy of the table and the window
    logic        bp_valid [ENTRY_COUNT];
    logic [31:0] bp_addr  [ENTRY_COUNT];
    logic [31:0] bp_orig  [ENTRY_COUNT];
    logic [31:0] win_base;
    logic [31:0] win_size;

    bp_result_t  expected_results [$];
    int          err_count   = 0;
    int          beat_count  = 0;
    bit          src_idle_en = 1'b0;
    bit          snk_idle_en = 1'b0;
    int          hold_cycles = 0;

    breakpoint_table #(.ENTRY_COUNT(ENTRY_COUNT)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1_500_000;
        $display("breakpoint_table test failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor
    function automatic bp_result_t predict_response(input logic [1:0] act,
                                                    input logic [31:0] pc,
                                                    input logic [31:0] word,
                                                    input logic [4:0] num);
        bp_result_t  r;
        logic [31:0] offset;
        bit          found;
        r      = '0;
        found  = 1'b0;
        offset = pc - win_base;   // wraps mod 2^32
        case (act)
            ACT_INSERT: begin
                if (offset >= win_size) begin
                    r.status = ST_OUTSIDE;
                end else if ((word & BREAK_MASK) == BREAK_WORD) begin
                    r.status = ST_ALREADY;
                end else begin
                    r.status = ST_FULL;
                    for (int i = 0; i < ENTRY_COUNT; i++) begin
                        if (!found && !bp_valid[i]) begin
                            found       = 1'b1;
                            bp_valid[i] = 1'b1;
                            bp_addr[i]  = pc;
                            bp_orig[i]  = word;
                            r.status    = ST_OK;
                            r.number    = i[4:0];
                            r.wreq      = 1'b1;
                            r.waddr     = pc;
                            r.wword     = BREAK_WORD;
                        end
                    end
                end
            end
            ACT_DELETE: begin
                if (int'(num) < ENTRY_COUNT && bp_valid[num]) begin
                    bp_valid[num] = 1'b0;
                    r.wreq  = 1'b1;
                    r.waddr = bp_addr[num];
                    r.wword = bp_orig[num];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            ACT_SCAN: begin
                for (int i = 0; i < ENTRY_COUNT; i++) begin
                    if (!found && bp_valid[i] && bp_addr[i] == pc) begin
                        found   = 1'b1;
                        r.hit   = 1'b1;
                        r.saved = bp_orig[i];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- result check
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (err_count < 10)
                $display("beat %0d: %s expected 0x%08h got 0x%08h", beat_count, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        bp_result_t got;
        bp_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[105:0];
            if (expected_results.size() == 0) begin
                if (err_count < 10)
                    $display("beat %0d: result with nothing outstanding: 0x%h",
                             beat_count, m_axis_tdata);
                err_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status",          32'(want.status), 32'(got.status));
                check_field("assigned_number", 32'(want.number), 32'(got.number));
                check_field("hit",             32'(want.hit),    32'(got.hit));
                check_field("saved_word",      want.saved,       got.saved);
                check_field("write_request",   32'(want.wreq),   32'(got.wreq));
                check_field("write_address",   want.waddr,       got.waddr);
                check_field("write_word",      want.wword,       got.wword);
            end
            beat_count++;
        end
    end

    // ---------------------------------------------------------------- result sink
    // long hold-off first, then random stall bursts when enabled
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- sender helpers
    // called at a falling edge; leaves tvalid high so back-to-back beats stay clean
    task automatic send_item(input logic [1:0] act, input logic [31:0] pc,
                             input logic [31:0] word, input logic [4:0] num);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, num, word, pc};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(predict_response(act, pc, word, num));
        @(negedge i_clk);
    endtask

    task automatic release_bus();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // table must be idle: every result taken, then a settling wait
    task automatic write_window(input logic [31:0] base, input logic [31:0] size);
        release_bus();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MEM_BASE;
        i_cfg_data  <= base;
        @(negedge i_clk);
        win_base     = base;
        i_cfg_index <= REG_MEM_SIZE;
        i_cfg_data  <= size;
        @(negedge i_clk);
        win_size     = size;
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // mostly well-formed traffic: in-window inserts, deletes and scans of live entries
    task automatic send_random_item();
        int          live [$];
        int unsigned roll;
        int unsigned pick;
        logic [1:0]  act;
        logic [31:0] pc;
        logic [31:0] word;
        logic [4:0]  num;
        for (int i = 0; i < ENTRY_COUNT; i++)
            if (bp_valid[i]) live.push_back(i);
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        pc   = $urandom;
        word = $urandom;
        num  = 5'($urandom_range(0, 31));
        if (roll < 42) begin
            act = ACT_INSERT;
            if (win_size != 0 && pick < 9) begin
                if (live.size() != 0 && pick < 2)
                    pc = bp_addr[live[$urandom_range(0, live.size() - 1)]];  // duplicate pc
                else
                    pc = win_base + ($urandom % win_size);
            end
            if ($urandom_range(0, 9) == 0)
                word = BREAK_WORD | (word & ~BREAK_MASK);
        end else if (roll < 70) begin
            act = ACT_DELETE;
            if (live.size() != 0 && pick < 7)
                num = 5'(live[$urandom_range(0, live.size() - 1)]);
        end else if (roll < 96) begin
            act = ACT_SCAN;
            if (live.size() != 0 && pick < 6)
                pc = bp_addr[live[$urandom_range(0, live.size() - 1)]];
            else if (win_size != 0 && pick < 8)
                pc = win_base + ($urandom % win_size);
        end else begin
            act = ACT_UNUSED;
        end
        send_item(act, pc, word, num);
    endtask

    task automatic run_window_phase(input logic [31:0] base, input logic [31:0] size,
                                    input int count);
        write_window(base, size);
        src_idle_en = ($urandom_range(0, 3) != 0);
        snk_idle_en = ($urandom_range(0, 3) != 0);
        repeat (count) send_random_item();
    endtask

    // ---------------------------------------------------------------- tests
    // reset window 0x80000000 + 128 MiB
    task automatic test_directed();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        send_item(ACT_INSERT, 32'h8000_0000, 32'h0000_0013, 5'd0);   // first entry
        send_item(ACT_INSERT, 32'h87ff_ffff, 32'hffff_ffff, 5'd0);   // last byte of window
        send_item(ACT_INSERT, 32'h8800_0000, 32'h0000_0013, 5'd0);   // one past the end
        send_item(ACT_INSERT, 32'h7fff_ffff, 32'h0000_0013, 5'd0);   // one below base
        send_item(ACT_INSERT, 32'h0000_0000, 32'h0000_0000, 5'd0);
        send_item(ACT_INSERT, 32'hffff_ffff, 32'h0000_0000, 5'd31);
        send_item(ACT_INSERT, 32'h8800_0000, BREAK_WORD,    5'd0);   // window test wins
        send_item(ACT_INSERT, 32'h8000_0100, 32'h002a_0000, 5'd0);   // already a break
        send_item(ACT_INSERT, 32'h8000_0104, 32'h002a_7fff, 5'd0);
        send_item(ACT_INSERT, 32'h8000_0108, 32'h002a_8000, 5'd0);   // just outside the pattern
        send_item(ACT_INSERT, 32'h8000_010c, 32'h002b_0000, 5'd0);
        send_item(ACT_INSERT, 32'h8000_0000, 32'hdead_beef, 5'd0);   // duplicate pc
        send_item(ACT_SCAN,   32'h8000_0000, 32'h0000_0000, 5'd0);   // lower number wins
        send_item(ACT_DELETE, 32'h0000_0000, 32'h0000_0000, 5'd0);
        send_item(ACT_SCAN,   32'h8000_0000, 32'hffff_ffff, 5'd31);  // now the duplicate
        send_item(ACT_DELETE, 32'hffff_ffff, 32'hffff_ffff, 5'd0);   // already freed
        send_item(ACT_DELETE, 32'h0000_0000, 32'h0000_0000, 5'd31);  // never used
        send_item(ACT_SCAN,   32'h1234_5678, 32'h0000_0000, 5'd0);   // miss
        send_item(ACT_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 5'd31);
        send_item(ACT_UNUSED, 32'h0000_0000, 32'h0000_0000, 5'd0);
        send_item(ACT_INSERT, 32'h8000_0200, 32'h0000_0073, 5'd0);   // reuses number 0
        send_item(ACT_SCAN,   32'h87ff_ffff, 32'h0000_0000, 5'd0);
        send_item(ACT_DELETE, 32'h0000_0000, 32'h0000_0000, 5'd1);
    endtask

    task automatic test_pool_full();
        int free_count;
        free_count = 0;
        for (int i = 0; i < ENTRY_COUNT; i++)
            if (!bp_valid[i]) free_count++;
        for (int i = 0; i < free_count; i++)
            send_item(ACT_INSERT, win_base + 32'(4 * i) + 32'h1000, $urandom & ~BREAK_MASK,
                      5'd0);
        send_item(ACT_INSERT, win_base + 32'h40, 32'h1111_1111, 5'd0);   // pool full
        send_item(ACT_INSERT, win_base + 32'h44, BREAK_WORD,    5'd0);   // break test first
        send_item(ACT_INSERT, win_base - 32'h4,  32'h1111_1111, 5'd0);   // window test first
        send_item(ACT_SCAN,   win_base + 32'h1010, 32'h0,       5'd0);
        send_item(ACT_DELETE, 32'h0, 32'h0, 5'd31);
        send_item(ACT_DELETE, 32'h0, 32'h0, 5'd17);
        send_item(ACT_INSERT, win_base + 32'h48, 32'h2222_2222, 5'd0);   // takes 17
        send_item(ACT_INSERT, win_base + 32'h4c, 32'h3333_3333, 5'd0);   // takes 31
        send_item(ACT_INSERT, win_base + 32'h50, 32'h4444_4444, 5'd0);   // full again
        for (int i = 0; i < ENTRY_COUNT; i += 2)
            send_item(ACT_DELETE, 32'h0, 32'h0, 5'(i));
    endtask

    // receiver stops for a long stretch while beats keep coming
    task automatic test_output_holdoff();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        hold_cycles = 500;
        repeat (14) send_random_item();
        release_bus();
        wait_drained();
    endtask

    // sender waits for every outstanding result before going on
    task automatic test_sender_pause();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        repeat (20) send_random_item();
        release_bus();
        wait_drained();
        repeat (20) send_random_item();
    endtask

    task automatic test_window_settings();
        run_window_phase(32'h8000_0000, 32'h0800_0000, 120);
        run_window_phase(32'h0000_0000, 32'h0000_0000, 40);    // empty window
        run_window_phase(32'hffff_ffff, 32'hffff_ffff, 120);   // largest, wrapping
        run_window_phase(32'hffff_fff0, 32'h0000_0040, 110);   // wraps past zero
        run_window_phase(32'h0000_0000, 32'hffff_ffff, 110);
        run_window_phase(32'h0000_1000, 32'h0000_0010, 110);   // tiny: many duplicates
        run_window_phase($urandom, $urandom, 110);
    endtask

    task automatic test_final_burst();
        write_window(32'h8000_0000, 32'h0000_4000);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        repeat (100) send_random_item();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_MEM_BASE;
        i_cfg_data    = '0;
        win_base      = MEM_BASE_RST;
        win_size      = MEM_SIZE_RST;
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            bp_valid[i] = 1'b0;
            bp_addr[i]  = '0;
            bp_orig[i]  = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_pool_full();
        test_output_holdoff();
        test_sender_pause();
        test_window_settings();
        test_final_burst();

        release_bus();
        wait_drained();
        repeat (2 * ENTRY_COUNT + 10) @(posedge i_clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("breakpoint_table test passed");
        else
            $display("breakpoint_table test failed");
        $finish;
    end

endmodule
